// ===== src/vtna_pkg.sv =====
// ----------------------------------------------------------------------------
// vtna_pkg
// Shared types, register map and constants for the vector to angle unit.
// ----------------------------------------------------------------------------
package vtna_pkg;

    // working width of the cordic x/y datapath (folded inputs grow by ~1.65)
    localparam int unsigned XW = 35;

    localparam int unsigned PROD_W = 66;

    // register map, index = paddr[3:2]
    localparam logic [1:0] REG_DEGREE_MODE     = 2'd0;
    localparam logic [1:0] REG_SYMMETRIC_RANGE = 2'd1;
    localparam logic [1:0] REG_MISSING_CODE    = 2'd2;
    localparam logic [1:0] REG_ZERO_TOLERANCE  = 2'd3;

    localparam logic [31:0] MISSING_RESET = 32'h8000_0000;
    localparam logic [19:0] ZERO_TOL_RESET = 20'd16;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    // binary angle scaling
    localparam logic signed [32:0] DEG_MULT = 33'sd360;
    localparam logic signed [32:0] RAD_MULT = 33'sd3373259426;
    localparam logic signed [PROD_W-1:0] DEG_ROUND = PROD_W'(66'sd1 <<< 10);
    localparam logic signed [PROD_W-1:0] RAD_ROUND = PROD_W'(66'sd1 <<< 39);
    localparam int unsigned DEG_SHIFT = 11;
    localparam int unsigned RAD_SHIFT = 40;
    localparam logic signed [31:0] DEG_FULL = 32'sd754974720;
    localparam logic signed [31:0] RAD_FULL = 32'sd13176795;
    localparam logic signed [31:0] DEG_HALF = 32'sd377487360;
    localparam logic signed [31:0] RAD_HALF = 32'sd6588397;

    typedef struct packed {
        logic        degree_mode;
        logic        symmetric_range;
        logic [31:0] missing_code;
        logic [19:0] zero_tolerance;
    } t_cfg;

    typedef struct packed {
        logic                 vld;
        logic                 miss;
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [31:0]          z;
    } t_cordic;

    typedef struct packed {
        logic [31:0] angle;
        logic        is_missing;
    } t_result;

    // atan(2^-i) in binary angle units, 2^32 per turn
    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] t;
        case (idx)
            0:  t = 32'd536870912;
            1:  t = 32'd316933406;
            2:  t = 32'd167458907;
            3:  t = 32'd85004756;
            4:  t = 32'd42667331;
            5:  t = 32'd21354465;
            6:  t = 32'd10679838;
            7:  t = 32'd5340245;
            8:  t = 32'd2670163;
            9:  t = 32'd1335087;
            10: t = 32'd667544;
            11: t = 32'd333772;
            12: t = 32'd166886;
            13: t = 32'd83443;
            14: t = 32'd41722;
            15: t = 32'd20861;
            16: t = 32'd10430;
            17: t = 32'd5215;
            18: t = 32'd2608;
            19: t = 32'd1304;
            20: t = 32'd652;
            21: t = 32'd326;
            22: t = 32'd163;
            23: t = 32'd81;
            24: t = 32'd41;
            25: t = 32'd20;
            26: t = 32'd10;
            27: t = 32'd5;
            28: t = 32'd3;
            29: t = 32'd1;
            30: t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== src/vtna_in_if.sv =====
// ----------------------------------------------------------------------------
// vtna_in_if
// Request channel carrying one (x, y) vector in signed Q1.30.
// ----------------------------------------------------------------------------
interface vtna_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;

    modport source (output valid, output vec_x, output vec_y, input ready);
    modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

// ===== src/vtna_out_if.sv =====
// ----------------------------------------------------------------------------
// vtna_out_if
// Result channel carrying one angle in signed Q10.21 and a missing flag.
// ----------------------------------------------------------------------------
interface vtna_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] angle;
    logic               is_missing;

    modport source (output valid, output angle, output is_missing, input ready);
    modport sink   (input valid, input angle, input is_missing, output ready);
endinterface

// ===== src/vector_to_normalised_angle_unit.sv =====
// ----------------------------------------------------------------------------
// vector_to_normalised_angle_unit
// atan2 of a Q1.30 vector as a normalised Q10.21 angle, pipelined CORDIC.
// ----------------------------------------------------------------------------
// The unit takes one vector per clock and returns one angle per vector, in
// order. The path is one entry stage (missing and near-zero tests, fold),
// one register per CORDIC micro-rotation, a multiply stage and a round/wrap
// stage that scale the binary angle to degrees or radians, and the output
// register. The rate is one vector per cycle, set by the fully unrolled
// rotation chain; a stall at the output is absorbed by a one-entry skid
// slot, after which the whole pipeline holds. Registers are
// written over APB at byte offsets 0x0 (degree mode), 0x4 (symmetric range),
// 0x8 (missing code) and 0xC (zero tolerance), and should be changed only
// while no vector is in flight.
module vector_to_normalised_angle_unit #(
    parameter int unsigned CORDIC_STAGES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vtna_in_if.sink     i_vec,
    vtna_out_if.source  o_ang,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    vtna_pkg::t_cfg    w_cfg;
    vtna_pkg::t_cordic w_stage [0:CORDIC_STAGES];
    logic              w_adv;
    logic              w_res_valid;
    vtna_pkg::t_result w_res;
    vtna_pkg::t_result w_out;

    vtna_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign i_vec.ready = w_adv;

    vtna_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_vec.valid),
        .i_vec_x (i_vec.vec_x),
        .i_vec_y (i_vec.vec_y),
        .i_cfg   (w_cfg),
        .o_q     (w_stage[0])
    );

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
        vtna_cordic_stage #(
            .IDX (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_d     (w_stage[k]),
            .o_q     (w_stage[k+1])
        );
    end

    vtna_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_d     (w_stage[CORDIC_STAGES]),
        .i_cfg   (w_cfg),
        .o_valid (w_res_valid),
        .o_res   (w_res)
    );

    vtna_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_data  (w_res),
        .o_adv   (w_adv),
        .o_valid (o_ang.valid),
        .o_data  (w_out),
        .i_ready (o_ang.ready)
    );

    assign o_ang.angle      = w_out.angle;
    assign o_ang.is_missing = w_out.is_missing;
endmodule

// ===== src/vtna_regs.sv =====
// ----------------------------------------------------------------------------
// vtna_regs
// APB configuration registers: angle unit, range, missing code, zero tolerance.
// ----------------------------------------------------------------------------
module vtna_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output vtna_pkg::t_cfg     o_cfg
);
    logic [1:0]     w_idx;
    logic           w_wr;
    vtna_pkg::t_cfg r_cfg;

    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.degree_mode     <= 1'b1;
            r_cfg.symmetric_range <= 1'b0;
            r_cfg.missing_code    <= vtna_pkg::MISSING_RESET;
            r_cfg.zero_tolerance  <= vtna_pkg::ZERO_TOL_RESET;
        end else if (w_wr) begin
            case (w_idx)
                vtna_pkg::REG_DEGREE_MODE:     r_cfg.degree_mode     <= pwdata[0];
                vtna_pkg::REG_SYMMETRIC_RANGE: r_cfg.symmetric_range <= pwdata[0];
                vtna_pkg::REG_MISSING_CODE:    r_cfg.missing_code    <= pwdata;
                vtna_pkg::REG_ZERO_TOLERANCE:  r_cfg.zero_tolerance  <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            vtna_pkg::REG_DEGREE_MODE:     prdata = {31'd0, r_cfg.degree_mode};
            vtna_pkg::REG_SYMMETRIC_RANGE: prdata = {31'd0, r_cfg.symmetric_range};
            vtna_pkg::REG_MISSING_CODE:    prdata = r_cfg.missing_code;
            vtna_pkg::REG_ZERO_TOLERANCE:  prdata = {12'd0, r_cfg.zero_tolerance};
            default:                       prdata = 32'd0;
        endcase
    end
endmodule

// ===== src/vtna_front.sv =====
// ----------------------------------------------------------------------------
// vtna_front
// Entry stage: missing and near-zero tests, fold into the right half plane.
// ----------------------------------------------------------------------------
module vtna_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic signed [31:0]  i_vec_x,
    input  logic signed [31:0]  i_vec_y,
    input  vtna_pkg::t_cfg      i_cfg,
    output vtna_pkg::t_cordic   o_q
);
    logic signed [32:0]           w_ax;
    logic signed [32:0]           w_ay;
    logic signed [32:0]           w_tol;
    logic signed [vtna_pkg::XW-1:0] w_x;
    logic signed [vtna_pkg::XW-1:0] w_y;
    vtna_pkg::t_cordic            n_q;
    vtna_pkg::t_cordic            r_q;

    assign w_x   = vtna_pkg::XW'(i_vec_x);
    assign w_y   = vtna_pkg::XW'(i_vec_y);
    assign w_ax  = i_vec_x[31] ? -33'(i_vec_x) : 33'(i_vec_x);
    assign w_ay  = i_vec_y[31] ? -33'(i_vec_y) : 33'(i_vec_y);
    assign w_tol = $signed({13'd0, i_cfg.zero_tolerance});

    always_comb begin
        n_q.vld  = i_valid;
        n_q.miss = (i_vec_x == $signed(i_cfg.missing_code))
                || (i_vec_y == $signed(i_cfg.missing_code));
        n_q.zero = (w_ax <= w_tol) && (w_ay <= w_tol);
        // left half plane: rotate by half a turn first
        if (i_vec_x[31]) begin
            n_q.x = -w_x;
            n_q.y = -w_y;
            n_q.z = vtna_pkg::HALF_TURN;
        end else begin
            n_q.x = w_x;
            n_q.y = w_y;
            n_q.z = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_adv) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

// ===== src/vtna_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// vtna_cordic_stage
// One registered CORDIC vectoring micro-rotation by atan(2^-IDX).
// ----------------------------------------------------------------------------
module vtna_cordic_stage #(
    parameter int unsigned IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  vtna_pkg::t_cordic i_d,
    output vtna_pkg::t_cordic o_q
);
    localparam logic [31:0] ANG = vtna_pkg::atan_turn(IDX);

    logic signed [vtna_pkg::XW-1:0] w_xs;
    logic signed [vtna_pkg::XW-1:0] w_ys;
    vtna_pkg::t_cordic              n_q;
    vtna_pkg::t_cordic              r_q;

    assign w_xs = i_d.x >>> IDX;
    assign w_ys = i_d.y >>> IDX;

    always_comb begin
        n_q = i_d;
        // drive y towards zero
        if (!i_d.y[vtna_pkg::XW-1]) begin
            n_q.x = i_d.x + w_ys;
            n_q.y = i_d.y - w_xs;
            n_q.z = i_d.z + ANG;
        end else begin
            n_q.x = i_d.x - w_ys;
            n_q.y = i_d.y + w_xs;
            n_q.z = i_d.z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_adv) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

// ===== src/vtna_scale.sv =====
// ----------------------------------------------------------------------------
// vtna_scale
// Binary angle to degrees or radians in Q10.21, rounding and range wrap.
// ----------------------------------------------------------------------------
module vtna_scale (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  vtna_pkg::t_cordic i_d,
    input  vtna_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    output vtna_pkg::t_result o_res
);
    logic [31:0]                        w_a;
    logic signed [32:0]                 w_op;
    logic signed [32:0]                 w_mult;
    logic signed [vtna_pkg::PROD_W-1:0] n_prod;
    logic signed [vtna_pkg::PROD_W-1:0] r_prod;
    logic                               r_p_vld;
    logic                               r_p_miss;

    logic signed [vtna_pkg::PROD_W-1:0] w_sum;
    logic signed [vtna_pkg::PROD_W-1:0] w_q;
    logic signed [31:0]                 w_r;
    logic signed [31:0]                 w_full;
    logic signed [31:0]                 w_half;
    vtna_pkg::t_result                  n_res;
    vtna_pkg::t_result                  r_res;
    logic                               r_vld;

    // multiply stage
    assign w_a    = i_d.zero ? 32'd0 : i_d.z;
    assign w_op   = i_cfg.symmetric_range ? $signed({w_a[31], w_a}) : $signed({1'b0, w_a});
    assign w_mult = i_cfg.degree_mode ? vtna_pkg::DEG_MULT : vtna_pkg::RAD_MULT;
    assign n_prod = vtna_pkg::PROD_W'(w_op) * vtna_pkg::PROD_W'(w_mult);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_adv) begin
            r_p_vld  <= i_d.vld;
            r_p_miss <= i_d.miss;
            r_prod   <= n_prod;
        end
    end

    // round half up, then wrap into the selected range
    assign w_sum  = r_prod + (i_cfg.degree_mode ? vtna_pkg::DEG_ROUND : vtna_pkg::RAD_ROUND);
    assign w_q    = i_cfg.degree_mode ? (w_sum >>> vtna_pkg::DEG_SHIFT)
                                      : (w_sum >>> vtna_pkg::RAD_SHIFT);
    assign w_r    = w_q[31:0];
    assign w_full = i_cfg.degree_mode ? vtna_pkg::DEG_FULL : vtna_pkg::RAD_FULL;
    assign w_half = i_cfg.degree_mode ? vtna_pkg::DEG_HALF : vtna_pkg::RAD_HALF;

    always_comb begin
        n_res.is_missing = r_p_miss;
        if (r_p_miss) begin
            n_res.angle = i_cfg.missing_code;
        end else if (i_cfg.symmetric_range) begin
            n_res.angle = (w_r >= w_half) ? -w_half : w_r;
        end else begin
            n_res.angle = (w_r >= w_full) ? 32'd0 : w_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= r_p_vld;
            r_res <= n_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;
endmodule

// ===== src/vtna_skid.sv =====
// ----------------------------------------------------------------------------
// vtna_skid
// Output register with a skid slot; its ready drives the pipeline advance.
// ----------------------------------------------------------------------------
module vtna_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  vtna_pkg::t_result i_data,
    output logic              o_adv,
    output logic              o_valid,
    output vtna_pkg::t_result o_data,
    input  logic              i_ready
);
    logic              r_out_valid;
    logic              r_skid_valid;
    vtna_pkg::t_result r_out;
    vtna_pkg::t_result r_skid;
    logic              w_in_fire;

    assign o_adv     = !r_skid_valid;
    assign w_in_fire = i_valid && !r_skid_valid;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_fire) begin
            if (!r_out_valid || i_ready) begin
                r_out       <= i_data;
                r_out_valid <= 1'b1;
            end else begin
                // result still waiting downstream: park the request
                r_skid       <= i_data;
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot full while output register empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> r_skid_valid)
        else $error("skid slot dropped a request");

    a_park_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && r_out_valid && !i_ready) |=> (r_skid_valid && r_out_valid))
        else $error("stalled result not parked in skid slot");
`endif
endmodule
